// ===== hdl/rid_pkg.sv =====
`default_nettype none
package rid_pkg;

	localparam int ROW_INDEX_BITS_DEF = 20;
	localparam int COL_INDEX_BITS_DEF = 16;

	localparam int ADDR_W = 4;

	// input function codes
	localparam logic [1:0] FUNC_SCALE   = 2'd0;
	localparam logic [1:0] FUNC_DATA    = 2'd1;
	localparam logic [1:0] FUNC_OUTLIER = 2'd2;

	// register indexes
	localparam logic [1:0] REG_FORMAT = 2'd0;
	localparam logic [1:0] REG_ROWS   = 2'd1;
	localparam logic [1:0] REG_COLS   = 2'd2;

	localparam logic [31:0] QNAN = 32'h7FC0_0000;

	// 1e-8f as mantissa * 2^exp
	localparam logic        [23:0] TINY_MANT = 24'hABCC77;
	localparam logic signed [6:0]  TINY_EXP  = -7'sd50;

	typedef enum logic [1:0] {
		CLS_ZERO,
		CLS_FIN,
		CLS_INF,
		CLS_NAN
	} cls_t;

	// unrounded product: value = mag * 2^expo
	typedef struct packed {
		logic               sign;
		cls_t               cls;
		logic        [31:0] mag;
		logic signed [6:0]  expo;
	} lane_t;

	typedef struct packed {
		logic        fmt;
		logic [20:0] rows;
		logic [16:0] cols;
	} cfg_t;

	typedef struct packed {
		logic valid;
		logic pair;
	} s1_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/rid_if.sv =====
`default_nettype none
interface rid_in_if #(
	parameter int RB = 20,
	parameter int CB = 16
);
	logic          valid;
	logic          ready;
	logic [1:0]    func;
	logic [15:0]   payload;
	logic [RB-1:0] outlier_row;
	logic [CB-1:0] outlier_col;

	modport source (output valid, func, payload, outlier_row, outlier_col, input ready);
	modport sink (input valid, func, payload, outlier_row, outlier_col, output ready);
endinterface

interface rid_out_if #(
	parameter int RB = 20,
	parameter int CB = 16
);
	logic          valid;
	logic          ready;
	logic [RB-1:0] out_row;
	logic [CB-1:0] out_col;
	logic [31:0]   value_bits;
	logic          last_of_run;

	modport source (output valid, out_row, out_col, value_bits, last_of_run, input ready);
	modport sink (input valid, out_row, out_col, value_bits, last_of_run, output ready);
endinterface
`default_nettype wire

// ===== hdl/rid_apb_regs.sv =====
`default_nettype none
module rid_apb_regs
	import rid_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	output cfg_t                   cfg
);
	cfg_t       cfg_q;
	logic [1:0] idx;

	assign idx    = paddr[3:2];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fmt  <= 1'b0;
			cfg_q.rows <= 21'd1;
			cfg_q.cols <= 17'd1;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_FORMAT: cfg_q.fmt  <= pwdata[0];
				REG_ROWS:   cfg_q.rows <= pwdata[20:0];
				REG_COLS:   cfg_q.cols <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_FORMAT: prdata = {31'b0, cfg_q.fmt};
			REG_ROWS:   prdata = {11'b0, cfg_q.rows};
			REG_COLS:   prdata = {15'b0, cfg_q.cols};
			default:    prdata = 32'b0;
		endcase
	end
endmodule
`default_nettype wire

// ===== hdl/rid_front.sv =====
`default_nettype none
module rid_front
	import rid_pkg::*;
#(
	parameter int ROW_INDEX_BITS = ROW_INDEX_BITS_DEF,
	parameter int COL_INDEX_BITS = COL_INDEX_BITS_DEF
)(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	rid_in_if.sink                         din,
	input  cfg_t                           cfg,
	input  wire logic                      adv,
	output s1_ctl_t                        ctl,
	output lane_t                          lane_s1 [2],
	output logic      [ROW_INDEX_BITS-1:0] row_s1 [2],
	output logic      [COL_INDEX_BITS-1:0] col_s1 [2]
);
	localparam int RB = ROW_INDEX_BITS;
	localparam int CB = COL_INDEX_BITS;

	typedef struct packed {
		logic               sign;
		cls_t               cls;
		logic        [23:0] m;
		logic signed [6:0]  e;
	} scale_t;

	function automatic scale_t decode(input logic [15:0] h, input logic tiny);
		scale_t s;
		s.sign = h[15];
		s.m    = {13'b0, 1'b1, h[9:0]};
		s.e    = $signed({2'b00, h[14:10]}) - 7'sd25;
		s.cls  = CLS_FIN;
		if (h[14:10] == 5'h1F) begin
			s.cls = (h[9:0] != 10'b0) ? CLS_NAN : CLS_INF;
		end else if (h[14:10] == 5'h00) begin
			s.m = {14'b0, h[9:0]};
			s.e = -7'sd24;
			if (h[9:0] == 10'b0) begin
				s.cls = CLS_ZERO;
				if (tiny) begin
					s.sign = 1'b0;
					s.cls  = CLS_FIN;
					s.m    = TINY_MANT;
					s.e    = TINY_EXP;
				end
			end
		end
		return s;
	endfunction

	function automatic lane_t mul(input scale_t s, input logic [7:0] q);
		lane_t      l;
		logic [7:0] qa;
		qa     = q[7] ? 8'(-q) : q;
		l.sign = s.sign ^ q[7];
		l.mag  = {24'b0, qa} * {8'b0, s.m};
		l.expo = s.e;
		unique case (s.cls)
			CLS_NAN:  l.cls = CLS_NAN;
			CLS_INF:  l.cls = (qa == 8'b0) ? CLS_NAN : CLS_INF;
			CLS_ZERO: l.cls = CLS_ZERO;
			default:  l.cls = (qa == 8'b0) ? CLS_ZERO : CLS_FIN;
		endcase
		return l;
	endfunction

	logic [15:0]   scale_q;
	logic [RB-1:0] row_q;
	logic [CB-1:0] col_q;
	logic          v_s1, pair_s1;

	logic          acc, ended0, ended1, pair, in_bnd;
	logic [16:0]   ccap, cl;
	logic [32:0]   rcap, rl;
	logic [CB-1:0] col1;
	logic [RB-1:0] row_adv;
	logic [7:0]    b, q0, q1;
	scale_t        sd, so;

	assign din.ready = !v_s1 || adv;
	assign acc       = din.valid && din.ready;
	assign ctl.valid = v_s1;
	assign ctl.pair  = pair_s1;

	always_comb begin
		ccap    = 17'd1 << CB;
		rcap    = 33'd1 << RB;
		cl      = (cfg.cols == 17'd0) ? 17'd1 : ((cfg.cols > ccap) ? ccap : cfg.cols);
		rl      = (cfg.rows == 21'd0) ? 33'd1 :
		          ((33'(cfg.rows) > rcap) ? rcap : 33'(cfg.rows));
		ended0  = 17'({1'b0, col_q} + 1'b1) >= cl;
		col1    = col_q + 1'b1;
		ended1  = 17'({1'b0, col1} + 1'b1) >= cl;
		pair    = cfg.fmt && !ended0;
		row_adv = (33'(row_q) + 33'd1 >= rl) ? '0 : row_q + 1'b1;
		in_bnd  = (33'(din.outlier_row) < rl) && (17'(din.outlier_col) < cl);
		b       = din.payload[7:0];
		q0      = cfg.fmt ? {{4{b[3]}}, b[3:0]} : b;
		q1      = {{4{b[7]}}, b[7:4]};
		sd      = decode(scale_q, 1'b1);
		so      = decode(din.payload, 1'b0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= '0;
			row_q   <= '0;
			col_q   <= '0;
			v_s1    <= 1'b0;
			pair_s1 <= 1'b0;
		end else if (acc) begin
			v_s1    <= 1'b0;
			pair_s1 <= 1'b0;
			unique case (din.func)
				FUNC_SCALE: scale_q <= din.payload;
				FUNC_DATA: begin
					v_s1    <= 1'b1;
					pair_s1 <= pair;
					if (pair) begin
						col_q <= ended1 ? '0 : col1 + 1'b1;
						if (ended1) row_q <= row_adv;
					end else begin
						col_q <= ended0 ? '0 : col1;
						if (ended0) row_q <= row_adv;
					end
				end
				FUNC_OUTLIER: v_s1 <= in_bnd;
				default: ;
			endcase
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			if (din.func == FUNC_OUTLIER) begin
				lane_s1[0] <= mul(so, 8'd1);
				row_s1[0]  <= din.outlier_row;
				col_s1[0]  <= din.outlier_col;
			end else begin
				lane_s1[0] <= mul(sd, q0);
				row_s1[0]  <= row_q;
				col_s1[0]  <= col_q;
			end
			lane_s1[1] <= mul(sd, q1);
			row_s1[1]  <= row_q;
			col_s1[1]  <= col1;
		end
	end
endmodule
`default_nettype wire

// ===== hdl/rid_round.sv =====
`default_nettype none
module rid_round
	import rid_pkg::*;
(
	input  lane_t       lane,
	output logic [31:0] bits
);
	logic [4:0]  p;
	logic [31:0] norm;
	logic [23:0] mant;
	logic [24:0] m25;
	logic        up;
	logic [9:0]  bexp;

	always_comb begin
		p = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (lane.mag[i]) p = 5'(i);
		end
		norm = lane.mag << (5'd31 - p);
		mant = norm[31:8];
		up   = norm[7] && ((|norm[6:0]) || mant[0]);
		m25  = {1'b0, mant} + {24'b0, up};
		bexp = {5'b0, p} + {{3{lane.expo[6]}}, lane.expo} + 10'd127 + {9'b0, m25[24]};
		unique case (lane.cls)
			CLS_NAN:  bits = QNAN;
			CLS_INF:  bits = {lane.sign, 8'hFF, 23'b0};
			CLS_ZERO: bits = {lane.sign, 31'b0};
			default:  bits = {lane.sign, bexp[7:0], m25[22:0]};
		endcase
	end
endmodule
`default_nettype wire

// ===== hdl/rowwise_int_dequantizer.sv =====
// Channel | dir | word                                          | accepted when
// din     | in  | func, payload, outlier_row, outlier_col       | valid && ready
// dout    | out | out_row, out_col, value_bits, last_of_run     | valid && ready
// apb     | in  | format, row_count, col_count at 0x0/0x4/0x8   | psel&penable&pwrite
//
// Two stages: s1 (position tracking, fp16 decode, 8x24 multiply), s2 (normalize,
// round to nearest even). The s1 and s2 registers lie between din and dout.
// One input word per cycle unless the output stalls; int4 bytes give two results
// (one at the end of a row), sent as two words, so the output port sets the rate.
// Reset: format int8, 1 row, 1 column, positions 0, scale 0 (acts as 1e-8).
// Output stall backs up s2, then s1, then din.ready, with no bubbles.
`default_nettype none
module rowwise_int_dequantizer
	import rid_pkg::*;
#(
	parameter int ROW_INDEX_BITS = ROW_INDEX_BITS_DEF,
	parameter int COL_INDEX_BITS = COL_INDEX_BITS_DEF
)(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	rid_in_if.sink                 din,
	rid_out_if.source              dout
);
	localparam int RB = ROW_INDEX_BITS;
	localparam int CB = COL_INDEX_BITS;

	cfg_t          cfg;
	s1_ctl_t       ctl;
	lane_t         lane_s1 [2];
	logic [RB-1:0] row_s1 [2];
	logic [CB-1:0] col_s1 [2];
	logic [31:0]   bits [2];

	// s2: rounded results, drained one per output word
	logic          v_s2, pair_s2, idx_q;
	logic [31:0]   bits_s2 [2];
	logic [RB-1:0] row_s2 [2];
	logic [CB-1:0] col_s2 [2];
	logic          last, adv;

	rid_apb_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg
	);

	rid_front #(
		.ROW_INDEX_BITS(RB),
		.COL_INDEX_BITS(CB)
	) u_front (
		.clk, .arst_n, .din, .cfg, .adv, .ctl, .lane_s1, .row_s1, .col_s1
	);

	rid_round u_round0 (.lane(lane_s1[0]), .bits(bits[0]));
	rid_round u_round1 (.lane(lane_s1[1]), .bits(bits[1]));

	// last word of the item currently in s2
	assign last = !pair_s2 || idx_q;
	assign adv  = !v_s2 || (dout.ready && last);

	assign dout.valid       = v_s2;
	assign dout.out_row     = idx_q ? row_s2[1] : row_s2[0];
	assign dout.out_col     = idx_q ? col_s2[1] : col_s2[0];
	assign dout.value_bits  = idx_q ? bits_s2[1] : bits_s2[0];
	assign dout.last_of_run = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			pair_s2 <= 1'b0;
			idx_q   <= 1'b0;
		end else if (adv) begin
			v_s2    <= ctl.valid;
			pair_s2 <= ctl.pair;
			idx_q   <= 1'b0;
		end else if (dout.ready) begin
			idx_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bits_s2 <= bits;
			row_s2  <= row_s1;
			col_s2  <= col_s1;
		end
	end

	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.ready && !dout.last_of_run |=> dout.valid && dout.last_of_run)
		else $error("second word of a pair missing");

	a_pair_same_row: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && pair_s2 |-> row_s2[1] == row_s2[0])
		else $error("int4 pair spans rows");

	a_idx_in_pair: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q |-> v_s2 && pair_s2)
		else $error("second lane selected outside a pair");
endmodule
`default_nettype wire
